// ----- src/soft_ack_frame_responder_defines.svh -----
// assertion macros for the frame responder
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef SOFT_ACK_FRAME_RESPONDER_DEFINES_SVH
`define SOFT_ACK_FRAME_RESPONDER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SACK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SACK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sack_pkg.sv -----
// shared types and constants of the frame responder
// no dependencies
package sack_pkg;

    // frame types from frame control bits 2:0
    localparam logic [2:0] FT_DATA   = 3'd1;
    localparam logic [2:0] FT_ACK    = 3'd2;
    localparam logic [2:0] FT_SIGNAL = 3'd3;
    localparam logic [2:0] FT_PROBE  = 3'd7;
    localparam int         ACK_REQ_BIT = 5;

    // reply sizes and vote arithmetic
    localparam logic [10:0] ACK_LEN      = 11'd13;
    localparam logic [10:0] VOTE_HDR_LEN = 11'd11;
    localparam logic [15:0] WIN_TOL      = 16'd3;

    // defaults of the top level parameters
    localparam int TIMER_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // decoded work kind handed from front to back
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_CAPTURE,
        KIND_PROBE,
        KIND_SIGNAL,
        KIND_ACK
    } t_kind;

    // result action code
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ACK    = 2'd1,
        ACT_VOTE   = 2'd2,
        ACT_RESULT = 2'd3
    } t_action;

    // configuration register index
    typedef enum logic [2:0] {
        CFG_OWN_ADDR  = 3'd0,
        CFG_IS_ROOT   = 3'd1,
        CFG_CONT_EN   = 3'd2,
        CFG_INIT_SEED = 3'd3,
        CFG_SEED_STEP = 3'd4
    } t_cfg_idx;

    // one classified frame in the queue
    typedef struct packed {
        t_kind       kind;
        logic        bcast;
        logic        round_clear;
        logic [7:0]  seq;
        logic [15:0] word;
        logic [15:0] phase;
    } t_work;

    // seed load request from the config port
    typedef struct packed {
        logic       load;
        logic [7:0] value;
    } t_seed_load;

    // one result beat
    typedef struct packed {
        t_action     action;
        logic [10:0] reply_length;
        logic [7:0]  reply_sequence;
        logic [15:0] reply_phase;
        logic [15:0] peer_phase;
        logic        peer_phase_new;
        logic        winning;
        logic        competing;
    } t_result;

endpackage

// ----- src/sack_front.sv -----
// front end: takes frame header beats, decodes type, compares addresses,
// computes the ack phase; depends on sack_pkg
module sack_front #(
    parameter int TIMER_BITS = sack_pkg::TIMER_BITS_DEF
) (
    input  logic                i_valid,
    input  logic                i_full,
    input  logic [7:0]          i_frame_control,
    input  logic [7:0]          i_sequence_number,
    input  logic [63:0]         i_address_field,
    input  logic [15:0]         i_word_field,
    input  logic [15:0]         i_arrival_time,
    input  logic [15:0]         i_cycle_start,
    input  logic                i_sending,
    input  logic                i_broadcasting,
    input  logic [63:0]         i_pending_receiver,
    input  logic                i_round_clear,
    input  logic [63:0]         i_own_address,
    input  logic                i_is_root,
    input  logic                i_contention_enable,
    output logic                o_ready,
    output logic                o_push,
    output sack_pkg::t_work     o_work
);
    import sack_pkg::*;

    localparam int DW = 33;

    logic [2:0]    ftype;
    logic          ack_req;
    logic          addr_match;
    logic          dest_match;
    logic [63:0]   dest;
    logic [DW-1:0] diff;
    logic [DW-1:0] fwd;
    logic [DW-1:0] mask;
    logic          late;
    logic [15:0]   phase;
    t_kind         kind;

    // handshake: queue space is the only back pressure
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign ftype      = i_frame_control[2:0];
    assign ack_req    = i_frame_control[ACK_REQ_BIT];
    assign addr_match = (i_address_field == i_pending_receiver);

    // destination is frame bytes 5..12 read in reverse order
    always_comb begin
        dest[7:0]  = i_word_field[15:8];
        dest[15:8] = i_word_field[7:0];
        for (int i = 2; i < 8; i++) begin
            dest[8*i +: 8] = i_address_field[8*(9-i) +: 8];
        end
    end
    assign dest_match = (dest == i_own_address);

    // wrap-aware phase since cycle start
    assign mask  = (DW'(1) << TIMER_BITS) - DW'(1);
    assign diff  = {17'd0, i_cycle_start} - {17'd0, i_arrival_time};
    assign late  = diff[TIMER_BITS-1];
    assign fwd   = ({17'd0, i_arrival_time} - {17'd0, i_cycle_start}) & mask;
    assign phase = (!i_is_root && late) ? fwd[15:0] : 16'd0;

    // classification in priority order
    always_comb begin
        kind = KIND_NONE;
        if (ftype == FT_ACK && i_sending && !i_broadcasting) begin
            kind = addr_match ? KIND_CAPTURE : KIND_NONE;
        end else if (i_contention_enable && ftype == FT_PROBE) begin
            if (i_sending && (addr_match || i_broadcasting)) begin
                kind = KIND_PROBE;
            end
        end else if (i_contention_enable && ftype == FT_SIGNAL) begin
            kind = KIND_SIGNAL;
        end else if (ftype == FT_DATA && ack_req && dest_match) begin
            kind = KIND_ACK;
        end
    end

    assign o_work.kind        = kind;
    assign o_work.bcast       = i_broadcasting;
    assign o_work.round_clear = i_round_clear;
    assign o_work.seq         = i_sequence_number;
    assign o_work.word        = i_word_field;
    assign o_work.phase       = phase;

endmodule

// ----- src/sack_queue.sv -----
// short queue of classified frames between front and back end
// depends on sack_pkg
module sack_queue #(
    parameter int DEPTH = sack_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sack_pkg::t_work i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output sack_pkg::t_work o_data
);
    import sack_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- src/sack_back.sv -----
// back end: holds contention and phase state, builds one result per frame
// into an output register; depends on sack_pkg
module sack_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  sack_pkg::t_work     i_work,
    input  logic                i_out_ready,
    input  logic [7:0]          i_seed_step,
    input  sack_pkg::t_seed_load i_seed_load,
    output logic                o_pop,
    output logic                o_out_valid,
    output sack_pkg::t_result   o_result
);
    import sack_pkg::*;

    logic        r_comp;
    logic        r_win;
    logic [10:0] r_vote_len;
    logic [7:0]  r_seed;
    logic [15:0] r_peer;
    logic        r_out_valid;
    t_result     r_result;

    logic        n_comp;
    logic        n_win;
    logic [10:0] n_vote_len;
    logic [7:0]  n_seed;
    logic [15:0] n_peer;
    t_result     n_result;

    logic        comp0;
    logic        win0;
    logic [10:0] seed_x7;
    logic [8:0]  seed_sum;
    logic        vote_ge;
    logic [15:0] vote_diff;

    // a frame moves on whenever the output register is free or drains
    assign o_pop       = !i_empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // vote arithmetic
    assign seed_x7   = ({3'd0, r_seed} << 3) - {3'd0, r_seed};
    assign seed_sum  = {1'b0, r_seed} + {1'b0, i_seed_step};
    assign vote_ge   = ({5'd0, r_vote_len} >= i_work.word);
    assign vote_diff = vote_ge ? ({5'd0, r_vote_len} - i_work.word)
                               : (i_work.word - {5'd0, r_vote_len});

    // state update and result for the frame at the queue head
    always_comb begin
        comp0      = i_work.round_clear ? 1'b0 : r_comp;
        win0       = i_work.round_clear ? 1'b0 : r_win;
        n_comp     = comp0;
        n_win      = win0;
        n_vote_len = r_vote_len;
        n_seed     = r_seed;
        n_peer     = r_peer;
        n_result   = '0;
        n_result.action = ACT_NONE;
        case (i_work.kind)
            KIND_CAPTURE: begin
                n_peer = i_work.word;
                n_result.peer_phase_new = 1'b1;
            end
            KIND_PROBE: begin
                if (!comp0) begin
                    n_comp = 1'b1;
                    n_win  = 1'b0;
                    if (!i_work.bcast) begin
                        n_vote_len = seed_x7;
                        n_seed     = {4'd0, seed_sum[3:0]};
                        n_result.action         = ACT_VOTE;
                        n_result.reply_length   = VOTE_HDR_LEN + seed_x7;
                        n_result.reply_sequence = i_work.seq;
                    end
                end
            end
            KIND_SIGNAL: begin
                n_result.action = ACT_RESULT;
                if (comp0) begin
                    n_win = (vote_diff <= WIN_TOL);
                end
            end
            KIND_ACK: begin
                n_result.action         = ACT_ACK;
                n_result.reply_length   = ACK_LEN;
                n_result.reply_sequence = i_work.seq;
                n_result.reply_phase    = i_work.phase;
            end
            default: begin
                n_result.action = ACT_NONE;
            end
        endcase
        n_result.peer_phase = n_peer;
        n_result.winning    = n_win;
        n_result.competing  = n_comp;
    end

    // protocol state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp      <= 1'b0;
            r_win       <= 1'b0;
            r_vote_len  <= '0;
            r_seed      <= '0;
            r_peer      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_comp     <= n_comp;
                r_win      <= n_win;
                r_vote_len <= n_vote_len;
                r_seed     <= n_seed;
                r_peer     <= n_peer;
            end
            if (i_seed_load.load) begin
                r_seed <= i_seed_load.value;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

// ----- src/soft_ack_frame_responder.sv -----
// Frame responder for soft acknowledgements: one received frame header in,
// one decision beat out. Takes one header every cycle while the queue has
// space; each result passes through a queue entry, then the output register.
// A queue of QUEUE_DEPTH headers between decode and state update lets the
// result stream stall without holding the input, so input keeps flowing until
// the queue and the output register are full. Configuration writes are taken
// every cycle and must be issued only while no frame is in flight; a write of
// initial_seed also reloads the vote seed.
// depends on sack_pkg, sack_front, sack_queue, sack_back and the defines header
`include "soft_ack_frame_responder_defines.svh"

module soft_ack_frame_responder #(
    parameter int TIMER_BITS  = sack_pkg::TIMER_BITS_DEF,
    parameter int QUEUE_DEPTH = sack_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // frame header beat
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] frame_control, [15:8] sequence_number, [79:16] address_field,
    // [95:80] word_field, [111:96] arrival_time, [127:112] cycle_start,
    // [128] sending, [129] broadcasting, [193:130] pending_receiver,
    // [194] round_clear, [199:195] zero
    input  logic [199:0] s_tdata,
    // decision beat
    output logic         m_tvalid,
    input  logic         m_tready,
    // [10:0] reply_length, [18:11] reply_sequence, [34:19] reply_phase,
    // [50:35] peer_phase, [51] peer_phase_new, [52] winning,
    // [53] competing, [55:54] zero
    output logic [55:0]  m_tdata,
    // [1:0] action
    output logic [1:0]   m_tuser,
    // configuration write
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import sack_pkg::*;

    logic [63:0] r_own_addr;
    logic        r_is_root;
    logic        r_cont_en;
    logic [7:0]  r_seed_step;

    logic        cfg_we;
    t_seed_load  seed_load;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    t_work       front_work;
    t_work       head_work;
    t_result     result;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr  <= '0;
            r_is_root   <= 1'b0;
            r_cont_en   <= 1'b1;
            r_seed_step <= '0;
        end else if (cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OWN_ADDR:  r_own_addr  <= i_cfg_data;
                CFG_IS_ROOT:   r_is_root   <= i_cfg_data[0];
                CFG_CONT_EN:   r_cont_en   <= i_cfg_data[0];
                CFG_SEED_STEP: r_seed_step <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign seed_load.load  = cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_INIT_SEED);
    assign seed_load.value = i_cfg_data[7:0];

    // decode
    sack_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .i_valid             (s_tvalid),
        .i_full              (q_full),
        .i_frame_control     (s_tdata[7:0]),
        .i_sequence_number   (s_tdata[15:8]),
        .i_address_field     (s_tdata[79:16]),
        .i_word_field        (s_tdata[95:80]),
        .i_arrival_time      (s_tdata[111:96]),
        .i_cycle_start       (s_tdata[127:112]),
        .i_sending           (s_tdata[128]),
        .i_broadcasting      (s_tdata[129]),
        .i_pending_receiver  (s_tdata[193:130]),
        .i_round_clear       (s_tdata[194]),
        .i_own_address       (r_own_addr),
        .i_is_root           (r_is_root),
        .i_contention_enable (r_cont_en),
        .o_ready             (s_tready),
        .o_push              (q_push),
        .o_work              (front_work)
    );

    // decoupling queue
    sack_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_work),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (head_work)
    );

    // state update and result register
    sack_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_work      (head_work),
        .i_out_ready (m_tready),
        .i_seed_step (r_seed_step),
        .i_seed_load (seed_load),
        .o_pop       (q_pop),
        .o_out_valid (m_tvalid),
        .o_result    (result)
    );

    // result beat packing
    assign m_tuser = result.action;
    assign m_tdata = {2'b00, result.competing, result.winning, result.peer_phase_new,
                      result.peer_phase, result.reply_phase, result.reply_sequence,
                      result.reply_length};

    // checks
    `SACK_ASSERT_NOW(a_ack_len, m_tvalid && (m_tuser == ACT_ACK), result.reply_length == ACK_LEN, "ack reply must be 13 bytes")
    `SACK_ASSERT_NOW(a_win_needs_comp, m_tvalid && result.winning, result.competing, "winning without a vote round")
    `SACK_ASSERT_NOW(a_capture_silent, m_tvalid && result.peer_phase_new, (m_tuser == ACT_NONE) && (result.reply_length == 11'd0), "phase capture must not reply")
    `SACK_ASSERT_NEXT(a_pop_gives_valid, q_pop, m_tvalid, "popped frame did not reach the output")

endmodule
